/* hdl/ct3_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ct3_pkg
// Shared types and constants of the 3x3 census transform.
// ----------------------------------------------------------------------------
package ct3_pkg;

	// register indexes (paddr[2])
	localparam logic REG_IDX_WIDTH  = 1'b0;
	localparam logic REG_IDX_HEIGHT = 1'b1;

	localparam int          REG_BITS       = 12;
	localparam logic [11:0] WIDTH_RESET    = 12'd640;
	localparam logic [11:0] HEIGHT_RESET   = 12'd480;
	localparam int          MAX_HEIGHT     = 2048;

	// results one pixel can release: interior, right border, bottom, corner
	localparam int N_SLOT = 4;

	// one result word, code in the lowest bits
	typedef struct packed {
		logic        frame_end;
		logic [10:0] column;
		logic [10:0] row;
		logic [7:0]  code;
	} result_t;

	// control from the pixel stage to the window
	typedef struct packed {
		logic adv;
		logic first_col;
	} win_ctl_t;

endpackage

/* hdl/ct3_line_store.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ct3_line_store
// Two line memories (older and newer row), one read and one write per cycle,
// registered read data with write-to-read forwarding on an address match.
// ----------------------------------------------------------------------------
module ct3_line_store #(
	parameter int DEPTH = 2048,
	parameter int DW    = 8,
	parameter int AW    = 11
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_older,
	input  logic [DW-1:0] wr_newer,
	output logic [DW-1:0] rd_older,
	output logic [DW-1:0] rd_newer
);

	logic [DW-1:0] older_mem [DEPTH];
	logic [DW-1:0] newer_mem [DEPTH];

	logic [DW-1:0] older_rd_q, newer_rd_q;
	logic [DW-1:0] older_fw_q, newer_fw_q;
	logic          fwd_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			older_mem[wr_addr] <= wr_older;
			newer_mem[wr_addr] <= wr_newer;
		end
	end

	// read port, data held until the next read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			older_rd_q <= older_mem[rd_addr];
			newer_rd_q <= newer_mem[rd_addr];
			older_fw_q <= wr_older;
			newer_fw_q <= wr_newer;
		end
	end

	// same entry written at the read edge: take the new data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0;
		end else if (rd_en) begin
			fwd_q <= wr_en && (wr_addr == rd_addr);
		end
	end

	assign rd_older = fwd_q ? older_fw_q : older_rd_q;
	assign rd_newer = fwd_q ? newer_fw_q : newer_rd_q;

endmodule

/* hdl/ct3_window.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ct3_window
// 3x3 pixel window and the four census codes of one pixel step: interior,
// right border replicated, bottom row replicated, and the bottom-right corner.
// ----------------------------------------------------------------------------
module ct3_window
	import ct3_pkg::*;
#(
	parameter int P = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  win_ctl_t              ctl,
	input  logic [2:0][P-1:0]     col_in,
	output logic [N_SLOT-1:0][7:0] codes
);

	typedef logic [2:0][2:0][P-1:0] win_t;

	win_t w_q, nw, tw, bw, bc;

	function automatic logic [7:0] census(win_t wv);
		logic [P-1:0] ctr;
		logic [7:0]   v;
		ctr  = wv[1][1];
		v[0] = ctr > wv[0][0];
		v[1] = ctr > wv[0][1];
		v[2] = ctr > wv[0][2];
		v[3] = ctr > wv[1][0];
		v[4] = ctr > wv[1][2];
		v[5] = ctr > wv[2][0];
		v[6] = ctr > wv[2][1];
		v[7] = ctr > wv[2][2];
		return v;
	endfunction

	// next window: shift in the new column, or fill at column zero
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (ctl.first_col) begin
				nw[i][0] = col_in[i];
				nw[i][1] = col_in[i];
				nw[i][2] = col_in[i];
			end else begin
				nw[i][0] = w_q[i][1];
				nw[i][1] = w_q[i][2];
				nw[i][2] = col_in[i];
			end
		end
	end

	// border variants
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			tw[i][0] = nw[i][1];
			tw[i][1] = nw[i][2];
			tw[i][2] = nw[i][2];
		end
		bw[0] = nw[1];
		bw[1] = nw[2];
		bw[2] = nw[2];
		bc[0] = tw[1];
		bc[1] = tw[2];
		bc[2] = tw[2];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q <= '0;
		end else if (ctl.adv) begin
			w_q <= nw;
		end
	end

	assign codes[0] = census(nw);
	assign codes[1] = census(tw);
	assign codes[2] = census(bw);
	assign codes[3] = census(bc);

endmodule

/* hdl/ct3_result_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ct3_result_queue
// Holds the results of one pixel step and sends them one word per cycle
// while m_tready is high, lowest slot first, through an output register.
// ----------------------------------------------------------------------------
module ct3_result_queue
	import ct3_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     load,
	input  logic [N_SLOT-1:0]        load_mask,
	input  result_t [N_SLOT-1:0]     load_res,
	output logic                     free,
	output logic                     m_tvalid,
	input  logic                     m_tready,
	output logic [31:0]              m_tdata,
	output logic                     m_tlast
);

	logic [N_SLOT-1:0]    mask_q;
	result_t [N_SLOT-1:0] res_q;
	logic                 ov_q;
	result_t              od_q;
	logic                 pop;
	logic [1:0]           sel;

	// lowest pending slot
	always_comb begin
		sel = '0;
		for (int i = N_SLOT - 1; i >= 0; i--) begin
			if (mask_q[i]) sel = 2'(i);
		end
	end

	assign pop  = (mask_q != '0) && (!ov_q || m_tready);
	assign free = (mask_q == '0) || (pop && $onehot(mask_q));

	// slot bundle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
		end else if (load && free) begin
			mask_q <= load_mask;
		end else if (pop) begin
			mask_q <= mask_q & (mask_q - 1'b1);
		end
	end

	always_ff @(posedge clk) begin
		if (load && free) res_q <= load_res;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (pop) begin
			ov_q <= 1'b1;
		end else if (m_tready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) od_q <= res_q[sel];
	end

	assign m_tvalid = ov_q;
	assign m_tdata  = {2'b00, od_q.column, od_q.row, od_q.code};
	assign m_tlast  = od_q.frame_end;

endmodule

/* hdl/census_transform_3x3.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// census_transform_3x3
// Streaming 3x3 census transform with replicated image borders.
// ----------------------------------------------------------------------------
// Gray pixels enter on the s_ channel in raster order, one word per pixel.
// Each m_ word carries the census code of one pixel with its row and column;
// m_tlast marks the last code of the frame. Codes trail the input by one row
// and one column: the pixel at (r, c) releases the code of (r-1, c-1), a row
// end also releases the right-border code, and the last row releases its own
// codes, so one pixel gives zero to four words, in raster order per pixel.
// A pixel is read from and written back to the two line memories at its
// column; the read data returns in the next cycle, when the window step and
// code compare follow. Words pass the pixel stage, result slots and output
// register. Throughput is one pixel per cycle while m_tready is high; a pixel
// that releases n > 1 words holds the input while the output sends them, one
// word per cycle. Image size comes from the APB registers image_width (0x0)
// and image_height (0x4), written while the stream is idle. Reset clears the
// window, position counters and handshake state; line memories need no
// clearing, row 0 fills both before they are read. When m_tready is low the
// output word holds, the queue fills, and s_tready drops until space frees.
// ----------------------------------------------------------------------------
module census_transform_3x3
	import ct3_pkg::*;
#(
	parameter int MAX_WIDTH  = 2048,
	parameter int PIXEL_BITS = 8
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// slave stream: [PIXEL_BITS-1:0] pixel, rest zero
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	input  logic [((PIXEL_BITS + 7) / 8) * 8 - 1:0] s_tdata,
	// master stream: [7:0] code, [18:8] row, [29:19] column
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	output logic [31:0]                            m_tdata,
	output logic                                   m_tlast,
	// configuration
	input  logic                                   psel,
	input  logic                                   penable,
	input  logic                                   pwrite,
	input  logic [2:0]                             paddr,
	input  logic [31:0]                            pwdata,
	output logic [31:0]                            prdata,
	output logic                                   pready
);

	localparam int P  = PIXEL_BITS;
	localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int WW = $clog2(MAX_WIDTH + 1);

	// configuration registers
	logic [REG_BITS-1:0] width_q, height_q;
	logic                cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_IDX_WIDTH:  width_q  <= pwdata[REG_BITS-1:0];
				REG_IDX_HEIGHT: height_q <= pwdata[REG_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_IDX_WIDTH:  prdata = {20'b0, width_q};
			REG_IDX_HEIGHT: prdata = {20'b0, height_q};
			default:        prdata = '0;
		endcase
	end

	// effective image size
	logic [WW-1:0] w_eff;
	logic [11:0]   h_eff;

	always_comb begin
		if (width_q == '0) w_eff = WW'(1);
		else if (32'(width_q) > 32'(MAX_WIDTH)) w_eff = WW'(MAX_WIDTH);
		else w_eff = WW'(width_q);
		if (height_q == '0) h_eff = 12'd1;
		else if (32'(height_q) > 32'(MAX_HEIGHT)) h_eff = 12'(MAX_HEIGHT);
		else h_eff = height_q;
	end

	// position of the incoming pixel
	logic [CW-1:0] col_q, cur_c;
	logic [10:0]   row_q, cur_r;
	logic [11:0]   row_pre;
	logic          col_wrap, cur_last_col, cur_last_row;
	logic          accept;

	always_comb begin
		col_wrap     = WW'(col_q) >= w_eff;
		row_pre      = col_wrap ? (12'(row_q) + 12'd1) : 12'(row_q);
		cur_r        = (row_pre >= h_eff) ? 11'd0 : row_pre[10:0];
		cur_c        = col_wrap ? '0 : col_q;
		cur_last_col = WW'(cur_c) == (w_eff - WW'(1));
		cur_last_row = 12'(cur_r) == (h_eff - 12'd1);
	end

	assign accept = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (cur_last_col) begin
				col_q <= '0;
				row_q <= cur_last_row ? 11'd0 : (cur_r + 11'd1);
			end else begin
				col_q <= cur_c + CW'(1);
				row_q <= cur_r;
			end
		end
	end

	// pixel stage: waits for the line read
	logic          s1_valid_q;
	logic [P-1:0]  pix_s1;
	logic [CW-1:0] c_s1;
	logic [10:0]   r_s1;
	logic          first_row_s1, first_col_s1, last_row_s1, last_col_s1;
	logic          s1_adv, q_free;
	logic [N_SLOT-1:0] res_mask;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1       <= s_tdata[P-1:0];
			c_s1         <= cur_c;
			r_s1         <= cur_r;
			first_row_s1 <= cur_r == 11'd0;
			first_col_s1 <= cur_c == '0;
			last_row_s1  <= cur_last_row;
			last_col_s1  <= cur_last_col;
		end
	end

	assign s1_adv   = s1_valid_q && ((res_mask == '0) || q_free);
	assign s_tready = !s1_valid_q || s1_adv;

	// line memories
	logic [P-1:0] rd_older, rd_newer, top_px, mid_px;

	assign top_px = first_row_s1 ? pix_s1 : rd_older;
	assign mid_px = first_row_s1 ? pix_s1 : rd_newer;

	ct3_line_store #(
		.DEPTH (MAX_WIDTH),
		.DW    (P),
		.AW    (CW)
	) u_lines (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (accept),
		.rd_addr  (cur_c),
		.wr_en    (s1_adv),
		.wr_addr  (c_s1),
		.wr_older (mid_px),
		.wr_newer (pix_s1),
		.rd_older (rd_older),
		.rd_newer (rd_newer)
	);

	// window and codes
	win_ctl_t              wctl;
	logic [N_SLOT-1:0][7:0] codes;

	assign wctl.adv       = s1_adv;
	assign wctl.first_col = first_col_s1;

	ct3_window #(
		.P (P)
	) u_window (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (wctl),
		.col_in ({pix_s1, mid_px, top_px}),
		.codes  (codes)
	);

	// result slots of this pixel
	result_t [N_SLOT-1:0] res;
	logic [10:0]          col11, colm11, rowm11;

	assign col11  = 11'(c_s1);
	assign colm11 = 11'(c_s1 - CW'(1));
	assign rowm11 = r_s1 - 11'd1;

	assign res_mask[0] = !first_row_s1 && !first_col_s1;
	assign res_mask[1] = !first_row_s1 && last_col_s1;
	assign res_mask[2] = last_row_s1 && !first_col_s1;
	assign res_mask[3] = last_row_s1 && last_col_s1;

	assign res[0] = '{frame_end: 1'b0, column: colm11, row: rowm11, code: codes[0]};
	assign res[1] = '{frame_end: 1'b0, column: col11,  row: rowm11, code: codes[1]};
	assign res[2] = '{frame_end: 1'b0, column: colm11, row: r_s1,   code: codes[2]};
	assign res[3] = '{frame_end: 1'b1, column: col11,  row: r_s1,   code: codes[3]};

	ct3_result_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (s1_valid_q && (res_mask != '0)),
		.load_mask (res_mask),
		.load_res  (res),
		.free      (q_free),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	// checks
	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> s1_valid_q)
		else $error("accepted pixel did not reach the pixel stage");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && !s1_adv) |=> (s1_valid_q && $stable(c_s1) && $stable(r_s1)))
		else $error("stalled pixel stage changed");

	a_silent_passes: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && (res_mask == '0)) |-> s1_adv)
		else $error("pixel with no results was held");

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the streaming 3x3 census transform.
// ----------------------------------------------------------------------------
// Pixels are queued by the stimulus block and sent by a bursty stream driver.
// Every accepted pixel runs through a census predictor that keeps its own
// line stores, window and raster position, and queues the codes it releases.
// The output monitor checks each code word against the oldest queued one.
// The receiver stalls on a rotating random pattern. Image sizes change over
// APB only while the stream is idle: small directed images, a size change in
// the middle of a frame, random frames, then short runs at zero and oversize
// registers.
// ----------------------------------------------------------------------------
module testbench
	import ct3_pkg::*;
();

	localparam int MAX_COLS     = 2048;
	localparam int DRAIN_CYCLES = 16;
	localparam int RANDOM_ITEMS = 300;
	localparam int SHORT_RUN    = 16;

	// pixel value styles for random images
	localparam int PIX_UNIFORM = 0;
	localparam int PIX_NARROW  = 1;
	localparam int PIX_BINARY  = 2;

	typedef logic [2:0][2:0][7:0] win_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = 8'd0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic        m_tlast;
	logic        psel     = 1'b0;
	logic        penable  = 1'b0;
	logic        pwrite   = 1'b0;
	logic [2:0]  paddr    = 3'd0;
	logic [31:0] pwdata   = 32'd0;
	logic [31:0] prdata;
	logic        pready;

	census_transform_3x3 u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always #6 clk = ~clk;

	// predictor state
	logic [7:0]  older_row [MAX_COLS];
	logic [7:0]  newer_row [MAX_COLS];
	win_t        census_win = '0;
	int          row_pos = 0;
	int          col_pos = 0;
	logic [11:0] cfg_width  = WIDTH_RESET;
	logic [11:0] cfg_height = HEIGHT_RESET;

	logic [7:0]  pixel_queue [$];
	result_t     code_queue [$];

	int err_count     = 0;
	int pixels_taken  = 0;
	int codes_seen    = 0;
	int frames_seen   = 0;
	int sizes_run     = 0;
	int random_pixels = 0;

	// driver and receiver pacing
	int          burst_left = 0;
	int          gap_left   = 0;
	int          stall_ptr  = 0;
	logic [31:0] stall_bits = '1;

	task automatic note_error(input string msg);
		err_count++;
		if (err_count <= 10)
			$display("%s", msg);
	endtask

	// zero acts as one, anything above the limit as the limit
	function automatic int clamp_size(input logic [11:0] v, input int limit);
		if (v == 0)
			return 1;
		if (int'(v) > limit)
			return limit;
		return int'(v);
	endfunction

	function automatic logic [7:0] census_code(input win_t w);
		logic [7:0] ctr;
		ctr = w[1][1];
		return {ctr > w[2][2], ctr > w[2][1], ctr > w[2][0], ctr > w[1][2],
			ctr > w[1][0], ctr > w[0][2], ctr > w[0][1], ctr > w[0][0]};
	endfunction

	task automatic expect_code(input logic [7:0] cd, input int r, input int c,
		input logic fe);
		result_t e;
		e.code      = cd;
		e.row       = r[10:0];
		e.column    = c[10:0];
		e.frame_end = fe;
		code_queue.push_back(e);
	endtask

	// one pixel through the census predictor; queues the codes it releases
	task automatic census_predict(input logic [7:0] px);
		int         w, h, r, c;
		logic [7:0] top, mid, v;
		win_t       tw, bw;
		w = clamp_size(cfg_width, MAX_COLS);
		h = clamp_size(cfg_height, MAX_HEIGHT);
		if (col_pos >= w) begin
			col_pos = 0;
			row_pos++;
		end
		if (row_pos >= h)
			row_pos = 0;
		r = row_pos;
		c = col_pos;

		// row 0 stands in for the replicated row above the image
		if (r == 0) begin
			top = px;
			mid = px;
		end else begin
			top = older_row[c];
			mid = newer_row[c];
		end
		older_row[c] = mid;
		newer_row[c] = px;

		// shift the window; column 0 replicates the left border
		for (int i = 0; i < 3; i++) begin
			v = (i == 0) ? top : (i == 1) ? mid : px;
			if (c == 0) begin
				census_win[i][0] = v;
				census_win[i][1] = v;
				census_win[i][2] = v;
			end else begin
				census_win[i][0] = census_win[i][1];
				census_win[i][1] = census_win[i][2];
				census_win[i][2] = v;
			end
		end

		// one more shift with the right border replicated
		for (int i = 0; i < 3; i++) begin
			tw[i][0] = census_win[i][1];
			tw[i][1] = census_win[i][2];
			tw[i][2] = census_win[i][2];
		end

		if (r >= 1) begin
			if (c >= 1)
				expect_code(census_code(census_win), r - 1, c - 1, 1'b0);
			if (c == w - 1)
				expect_code(census_code(tw), r - 1, c, 1'b0);
		end
		// last row: the row below replicates the current one
		if (r == h - 1) begin
			for (int j = 0; j < 3; j++) begin
				bw[0][j] = census_win[1][j];
				bw[1][j] = census_win[2][j];
				bw[2][j] = census_win[2][j];
			end
			if (c >= 1)
				expect_code(census_code(bw), r, c - 1, 1'b0);
			if (c == w - 1) begin
				for (int j = 0; j < 3; j++) begin
					bw[0][j] = tw[1][j];
					bw[1][j] = tw[2][j];
					bw[2][j] = tw[2][j];
				end
				expect_code(census_code(bw), r, c, 1'b1);
			end
		end

		col_pos = c + 1;
		if (col_pos >= w) begin
			col_pos = 0;
			row_pos = r + 1;
			if (row_pos >= h)
				row_pos = 0;
		end
	endtask

	// stream driver: bursts of random length, random gaps between them
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				census_predict(s_tdata);
				pixels_taken++;
			end
			if (!s_tvalid || s_tready) begin
				if (gap_left > 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (pixel_queue.size() != 0) begin
					s_tvalid <= 1'b1;
					s_tdata  <= pixel_queue.pop_front();
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(0, 24);
						gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver stall pattern, redrawn whenever the bit pointer wraps to zero
	always @(posedge clk) begin
		if (stall_ptr == 0) begin
			case ($urandom_range(0, 3))
				0: stall_bits = '1;
				1: stall_bits = $urandom | $urandom;
				2: stall_bits = $urandom & $urandom;
				default: stall_bits = $urandom;
			endcase
		end
		m_tready <= stall_bits[stall_ptr];
		stall_ptr = (stall_ptr + 1) % 32;
	end

	// output monitor
	result_t got, want;
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got.code      = m_tdata[7:0];
			got.row       = m_tdata[18:8];
			got.column    = m_tdata[29:19];
			got.frame_end = m_tlast;
			codes_seen++;
			if (got.frame_end)
				frames_seen++;
			if (code_queue.size() == 0) begin
				note_error($sformatf("unexpected word: code %02h row %0d col %0d last %0b",
					got.code, got.row, got.column, got.frame_end));
			end else begin
				want = code_queue.pop_front();
				if (got !== want)
					note_error($sformatf({"mismatch: expected code %02h row %0d col %0d ",
						"last %0b, got code %02h row %0d col %0d last %0b"},
						want.code, want.row, want.column, want.frame_end,
						got.code, got.row, got.column, got.frame_end));
			end
		end
	end

	// APB write, then read back
	task automatic reg_write(input logic idx, input logic [11:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= {20'd0, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (idx == REG_IDX_WIDTH)
			cfg_width = value;
		else
			cfg_height = value;
		@(posedge clk);
		psel    <= 1'b1;
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		if (prdata[11:0] !== value)
			note_error($sformatf("register %0d reads %03h, wrote %03h",
				idx, prdata[11:0], value));
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_size(input logic [11:0] w, input logic [11:0] h);
		reg_write(REG_IDX_WIDTH, w);
		reg_write(REG_IDX_HEIGHT, h);
		sizes_run++;
	endtask

	// all pixels sent, all codes back, then a drain wait for the pipeline
	task automatic wait_idle();
		do
			@(negedge clk);
		while (pixel_queue.size() != 0 || s_tvalid || code_queue.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	function automatic logic [7:0] random_pixel(input int style, input logic [7:0] base);
		case (style)
			PIX_NARROW: return base + 8'($urandom_range(0, 2));
			PIX_BINARY: return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
			default:    return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// whole frames at the current size, random content
	task automatic send_frames(input int frames, input int style);
		int         n;
		logic [7:0] base;
		n    = clamp_size(cfg_width, MAX_COLS) * clamp_size(cfg_height, MAX_HEIGHT) * frames;
		base = 8'($urandom_range(0, 253));
		for (int k = 0; k < n; k++)
			pixel_queue.push_back(random_pixel(style, base));
		random_pixels += n;
		wait_idle();
	endtask

	// a run of random pixels at the current size, not tied to frame ends
	task automatic send_pixels(input int n, input int style);
		logic [7:0] base;
		base = 8'($urandom_range(0, 253));
		for (int k = 0; k < n; k++)
			pixel_queue.push_back(random_pixel(style, base));
		wait_idle();
	endtask

	initial begin
		#20_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		logic [7:0] small_img [9];
		small_img = '{8'd0, 8'd255, 8'd128, 8'd255, 8'd128, 8'd0, 8'd128, 8'd1, 8'd254};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// 3x3 image with extreme, equal and near-equal pixels
		set_size(12'd3, 12'd3);
		foreach (small_img[k])
			pixel_queue.push_back(small_img[k]);
		wait_idle();

		// single-pixel images: plain 1x1 and zero-size registers
		set_size(12'd1, 12'd1);
		pixel_queue.push_back(8'hFF);
		wait_idle();
		set_size(12'd0, 12'd0);
		pixel_queue.push_back(8'h00);
		wait_idle();

		// width shrinks mid-frame: row 1 is done up to column 1, the
		// next pixel wraps to row 2 column 0, two pixels end the frame
		set_size(12'd5, 12'd4);
		for (int k = 0; k < 7; k++)
			pixel_queue.push_back(8'($urandom_range(0, 255)));
		wait_idle();
		set_size(12'd2, 12'd3);
		pixel_queue.push_back(8'hFF);
		pixel_queue.push_back(8'h00);
		wait_idle();

		// height shrinks below the current row: the next pixel restarts the frame
		set_size(12'd3, 12'd4);
		for (int k = 0; k < 6; k++)
			pixel_queue.push_back(8'($urandom_range(0, 255)));
		wait_idle();
		reg_write(REG_IDX_HEIGHT, 12'd2);
		send_frames(1, PIX_UNIFORM);

		// random small images
		random_pixels = 0;
		while (random_pixels < RANDOM_ITEMS) begin
			set_size(12'($urandom_range(1, 12)), 12'($urandom_range(1, 6)));
			send_frames($urandom_range(1, 2), $urandom_range(PIX_UNIFORM, PIX_BINARY));
		end

		// short runs: full-width row with zero height, the same row on with an
		// oversize width, then a single column with oversize height below it
		set_size(12'd2048, 12'd0);
		send_pixels(SHORT_RUN, PIX_UNIFORM);
		set_size(12'd4095, 12'd1);
		send_pixels(SHORT_RUN, PIX_NARROW);
		set_size(12'd0, 12'd4095);
		send_pixels(SHORT_RUN, PIX_UNIFORM);

		wait_idle();
		$display("Ran %0d image sizes: %0d pixels in, %0d codes out, %0d frame ends.",
			sizes_run, pixels_taken, codes_seen, frames_seen);
		$display("Errors: %0d", err_count);
		if (err_count == 0 && code_queue.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

/* files.f */
hdl/ct3_pkg.sv
hdl/ct3_line_store.sv
hdl/ct3_window.sv
hdl/ct3_result_queue.sv
hdl/census_transform_3x3.sv
dv/testbench.sv
